[rtl/core/kabf_pkg.sv]
package kabf_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ANG_NOISE_W  = 17;
  localparam int BIAS_NOISE_W = 17;
  localparam int MEAS_NOISE_W = 20;
  localparam int TSTEP_W      = 17;
  localparam int MEAS_W       = 25;
  localparam int RATE_W       = 28;
  localparam int EST_W        = 32;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] ADDR_ANGLE_NOISE   = 4'h0;
  localparam logic [CFG_AW-1:0] ADDR_BIAS_NOISE    = 4'h4;
  localparam logic [CFG_AW-1:0] ADDR_MEASURE_NOISE = 4'h8;
  localparam logic [CFG_AW-1:0] ADDR_TIME_STEP     = 4'hC;

  localparam logic [ANG_NOISE_W-1:0]  RST_ANGLE_NOISE   = 17'd66;
  localparam logic [BIAS_NOISE_W-1:0] RST_BIAS_NOISE    = 17'd197;
  localparam logic [MEAS_NOISE_W-1:0] RST_MEASURE_NOISE = 20'd1966;
  localparam logic [TSTEP_W-1:0]      RST_TIME_STEP     = 17'd655;

  // ALU operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // register file indexes
  localparam int NREG = 16;
  localparam logic [3:0] R_ANG   = 4'd0;
  localparam logic [3:0] R_BIAS  = 4'd1;
  localparam logic [3:0] R_PAA   = 4'd2;
  localparam logic [3:0] R_PAB   = 4'd3;
  localparam logic [3:0] R_PBA   = 4'd4;
  localparam logic [3:0] R_PBB   = 4'd5;
  localparam logic [3:0] R_DT    = 4'd6;
  localparam logic [3:0] R_QA    = 4'd7;
  localparam logic [3:0] R_QB    = 4'd8;
  localparam logic [3:0] R_RM    = 4'd9;
  localparam logic [3:0] R_MEAS  = 4'd10;
  localparam logic [3:0] R_RATE  = 4'd11;
  localparam logic [3:0] R_T0    = 4'd12;
  localparam logic [3:0] R_T1    = 4'd13;
  localparam logic [3:0] R_K0    = 4'd14;
  localparam logic [3:0] R_K1    = 4'd15;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [3:0] dst;
  } kabf_instr_t;

  localparam int NPROG = 22;

  function automatic kabf_instr_t prog(input logic [4:0] pc);
    kabf_instr_t r;
    case (pc)
      // predict
      5'd0:  r = '{OP_SUB, R_RATE, R_BIAS, R_T0};
      5'd1:  r = '{OP_MUL, R_DT,   R_T0,   R_T0};
      5'd2:  r = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
      5'd3:  r = '{OP_MUL, R_DT,   R_PBB,  R_T1};
      5'd4:  r = '{OP_SUB, R_T1,   R_PAB,  R_T0};
      5'd5:  r = '{OP_SUB, R_T0,   R_PBA,  R_T0};
      5'd6:  r = '{OP_ADD, R_T0,   R_QA,   R_T0};
      5'd7:  r = '{OP_MUL, R_DT,   R_T0,   R_T0};
      5'd8:  r = '{OP_ADD, R_PAA,  R_T0,   R_PAA};
      5'd9:  r = '{OP_SUB, R_PAB,  R_T1,   R_PAB};
      5'd10: r = '{OP_SUB, R_PBA,  R_T1,   R_PBA};
      5'd11: r = '{OP_MUL, R_QB,   R_DT,   R_T0};
      5'd12: r = '{OP_ADD, R_PBB,  R_T0,   R_PBB};
      // update
      5'd13: r = '{OP_ADD, R_PAA,  R_RM,   R_T1};
      5'd14: r = '{OP_DIV, R_PAA,  R_T1,   R_K0};
      5'd15: r = '{OP_DIV, R_PBA,  R_T1,   R_K1};
      5'd16: r = '{OP_SUB, R_MEAS, R_ANG,  R_T0};
      5'd17: r = '{OP_MUL, R_K1,   R_T0,   R_T1};
      5'd18: r = '{OP_ADD, R_BIAS, R_T1,   R_BIAS};
      5'd19: r = '{OP_MUL, R_K0,   R_T0,   R_T0};
      5'd20: r = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
      // covariance update handled in kabf_dp as four multiplies and four subtracts
      default: r = '{OP_MUL, R_K0, R_PAA, R_T0};
    endcase
    return r;
  endfunction

endpackage

[rtl/core/kabf_if.sv]
interface kabf_in_if;
  import kabf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measured_angle;
  logic signed [RATE_W-1:0] gyro_rate;
  modport source (output valid, measured_angle, gyro_rate, input ready);
  modport sink   (input valid, measured_angle, gyro_rate, output ready);
endinterface

interface kabf_out_if;
  import kabf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimated_angle;
  modport source (output valid, estimated_angle, input ready);
  modport sink   (input valid, estimated_angle, output ready);
endinterface

[rtl/core/kalman_angle_bias_filter.sv]
// channel | dir | payload                          | transaction
// in      | in  | measured_angle[25], gyro_rate[28] | in_valid & in_ready
// out     | out | estimated_angle[32]              | out_valid & out_ready
// cfg     | in  | APB, 4 regs at 0x0..0xC          | psel & penable & pwrite
// One item at a time: 29 steps on a shared ALU; multiply uses four half-width
// partial products, divide makes one quotient bit per cycle over W+FRAC+1 = 49
// bits (short cut when numerator or divisor is zero); 17 add/sub, 10 mul, 2 div.
// Reset (rst_n low, synchronous) zeroes state and loads the default noises and time step.
// The result register holds until out_ready; no new item is taken meanwhile.
module kalman_angle_bias_filter #(
  parameter int FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = kabf_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kabf_in_if.sink                       in_ch,
  kabf_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [kabf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [kabf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [kabf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import kabf_pkg::*;

  logic [ANG_NOISE_W-1:0]  qa_r;
  logic [BIAS_NOISE_W-1:0] qb_r;
  logic [MEAS_NOISE_W-1:0] rm_r;
  logic [TSTEP_W-1:0]      dt_r;
  logic load, issue, alu_done;
  logic [5:0] step;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= RST_ANGLE_NOISE;
      qb_r <= RST_BIAS_NOISE;
      rm_r <= RST_MEASURE_NOISE;
      dt_r <= RST_TIME_STEP;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        ADDR_ANGLE_NOISE:   qa_r <= cfg_pwdata[ANG_NOISE_W-1:0];
        ADDR_BIAS_NOISE:    qb_r <= cfg_pwdata[BIAS_NOISE_W-1:0];
        ADDR_MEASURE_NOISE: rm_r <= cfg_pwdata[MEAS_NOISE_W-1:0];
        ADDR_TIME_STEP:     dt_r <= cfg_pwdata[TSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_ANGLE_NOISE:   cfg_prdata = CFG_DW'(qa_r);
      ADDR_BIAS_NOISE:    cfg_prdata = CFG_DW'(qb_r);
      ADDR_MEASURE_NOISE: cfg_prdata = CFG_DW'(rm_r);
      ADDR_TIME_STEP:     cfg_prdata = CFG_DW'(dt_r);
      default:            cfg_prdata = '0;
    endcase
  end

  kabf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .load(load),
    .issue(issue), .step(step), .alu_done(alu_done)
  );

  kabf_dp #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .load(load), .issue(issue), .step(step),
    .alu_done(alu_done), .meas(in_ch.measured_angle), .rate(in_ch.gyro_rate),
    .qa(qa_r), .qb(qb_r), .rm(rm_r), .dt(dt_r), .angle(out_ch.estimated_angle)
  );
endmodule

[rtl/core/kabf_ctrl.sv]
module kabf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 load,
  output logic                 issue,
  output logic [5:0]           step,
  input  logic                 alu_done
);
  import kabf_pkg::*;

  // steps 0..20 from program, 21..24 covariance multiplies, 25..28 subtracts
  localparam logic [5:0] LAST_STEP = 6'd28;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign load      = in_valid && in_ready;
  assign issue     = (state_r == S_RUN);
  assign step      = step_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: state_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_done) begin
          if (step_r == LAST_STEP) begin
            state_nxt = S_OUT;
          end else begin
            step_nxt  = step_r + 6'd1;
            state_nxt = S_RUN;
          end
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP) else $error("step out of range");
  a_issue_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (state_r == S_WAIT)) else $error("issue not followed by wait");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

[rtl/core/kabf_alu.sv]
module kabf_alu #(
  parameter int FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = kabf_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [1:0]                   op,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res
);
  import kabf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int HW  = (W + 1) / 2;
  localparam int PW  = 2 * W;
  localparam int QW  = W + FRAC_BITS + 1;
  localparam int CW  = $clog2(QW + 1) + 1;
  localparam logic [W:0] VMAXU = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] VMINU = {2'b01, {(W-1){1'b0}}};

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_DIV  = 3'd2;
  localparam logic [2:0] A_FIN  = 3'd3;
  localparam logic [2:0] A_DONE = 3'd4;

  logic [2:0]   st_r, st_nxt;
  logic [1:0]   op_r;
  logic         neg_r;
  logic [W-1:0] ua_r, ub_r;
  logic [PW+1:0] acc_r, acc_nxt;   // product magnitude, or quotient
  logic [1:0]   mcnt_r;
  logic [W:0]   rem_r, rem_nxt;
  logic [QW-1:0] num_r, num_nxt;
  logic [CW-1:0] dcnt_r;
  logic signed [W-1:0] res_r, res_nxt;
  logic          rnd_r;

  logic [W-1:0] ua, ub;
  logic         sa_neg, sb_neg;
  logic signed [W:0] sum;
  logic [HW-1:0] ahalf, bhalf;
  logic [2*HW-1:0] pp;
  logic [W:0]   rem_sh;
  logic [PW+1:0] mag, lim;

  assign sa_neg = a[W-1];
  assign sb_neg = b[W-1];
  assign ua = sa_neg ? W'(-a) : W'(a);
  assign ub = sb_neg ? W'(-b) : W'(b);
  assign sum = (op == OP_ADD) ? ((W+1)'(a) + (W+1)'(b)) : ((W+1)'(a) - (W+1)'(b));

  // one half-width partial product per cycle
  assign ahalf = mcnt_r[0] ? HW'(ua_r >> HW) : HW'(ua_r);
  assign bhalf = mcnt_r[1] ? HW'(ub_r >> HW) : HW'(ub_r);
  assign pp    = ahalf * bhalf;
  assign rem_sh = {rem_r[W-1:0], num_r[QW-1]};

  always_comb begin
    lim = neg_r ? (PW+2)'(VMINU) : (PW+2)'(VMAXU);
    if (op_r == OP_MUL)
      mag = (acc_r + ((PW+2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    else
      mag = acc_r + (PW+2)'(rnd_r);
    if (mag > lim) mag = lim;
  end

  always_comb begin
    st_nxt  = st_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    res_nxt = res_r;
    case (st_r)
      A_IDLE: begin
        if (start) begin
          case (op)
            OP_ADD, OP_SUB: begin
              if (sum > (W+1)'(signed'(VMAXU))) res_nxt = W'(VMAXU);
              else if (sum < -(W+1)'(signed'(VMINU))) res_nxt = W'(VMINU);
              else res_nxt = W'(sum);
              st_nxt = A_DONE;
            end
            OP_MUL: begin
              acc_nxt = '0;
              st_nxt  = A_MUL;
            end
            default: begin
              acc_nxt = '0;
              rem_nxt = '0;
              num_nxt = QW'(ua) << FRAC_BITS;
              if (a == '0) begin
                res_nxt = '0;
                st_nxt  = A_DONE;
              end else if (b == '0) begin
                res_nxt = sa_neg ? W'(VMINU) : W'(VMAXU);
                st_nxt  = A_DONE;
              end else begin
                st_nxt = A_DIV;
              end
            end
          endcase
        end
      end
      A_MUL: begin
        acc_nxt = acc_r + ((PW+2)'(pp) << (HW * (32'(mcnt_r[0]) + 32'(mcnt_r[1]))));
        if (mcnt_r == 2'd3) st_nxt = A_FIN;
      end
      A_DIV: begin
        if (rem_sh >= (W+1)'(ub_r)) begin
          rem_nxt = rem_sh - (W+1)'(ub_r);
          acc_nxt = {acc_r[PW:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          acc_nxt = {acc_r[PW:0], 1'b0};
        end
        num_nxt = {num_r[QW-2:0], 1'b0};
        if (dcnt_r == CW'(QW - 1)) st_nxt = A_FIN;
      end
      A_FIN: begin
        res_nxt = neg_r ? W'(-mag) : W'(mag);
        st_nxt  = A_DONE;
      end
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      mcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == A_MUL) mcnt_r <= mcnt_r + 2'd1;
      else mcnt_r <= '0;
      if (st_r == A_DIV) dcnt_r <= dcnt_r + CW'(1);
      else dcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    res_r <= res_nxt;
    if (st_r == A_DIV) rnd_r <= ((rem_nxt << 1) >= (W+1)'(ub_r));
    if (start && st_r == A_IDLE) begin
      op_r  <= op;
      neg_r <= sa_neg ^ sb_neg;
      ua_r  <= ua;
      ub_r  <= ub;
    end
  end

  assign done = (st_r == A_DONE);
  assign res  = res_r;
endmodule

[rtl/core/kabf_dp.sv]
module kabf_dp #(
  parameter int FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = kabf_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  issue,
  input  logic [5:0]                            step,
  output logic                                  alu_done,
  input  logic signed [kabf_pkg::MEAS_W-1:0]    meas,
  input  logic signed [kabf_pkg::RATE_W-1:0]    rate,
  input  logic [kabf_pkg::ANG_NOISE_W-1:0]      qa,
  input  logic [kabf_pkg::BIAS_NOISE_W-1:0]     qb,
  input  logic [kabf_pkg::MEAS_NOISE_W-1:0]     rm,
  input  logic [kabf_pkg::TSTEP_W-1:0]          dt,
  output logic signed [kabf_pkg::EST_W-1:0]     angle
);
  import kabf_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] rf_r [NREG];
  logic signed [W-1:0] p00_r, p01_r, c0_r, c1_r, c2_r, c3_r;
  kabf_instr_t ins;
  logic [1:0] op;
  logic [3:0] sa, sb, dst;
  logic signed [W-1:0] opa, opb, res;

  function automatic logic signed [W-1:0] satw(input logic signed [63:0] v);
    if (v > 64'(SMAX)) return SMAX;
    if (v < 64'(SMIN)) return SMIN;
    return W'(v);
  endfunction

  assign ins = prog(step[4:0]);

  // extra steps: 21..24 products K*P, 25..28 subtracts
  always_comb begin
    op  = ins.op;
    opa = rf_r[ins.src_a];
    opb = rf_r[ins.src_b];
    dst = ins.dst;
    sa  = ins.src_a;
    sb  = ins.src_b;
    case (step)
      6'd21: begin op = OP_MUL; opa = rf_r[R_K0]; opb = p00_r; end
      6'd22: begin op = OP_MUL; opa = rf_r[R_K0]; opb = p01_r; end
      6'd23: begin op = OP_MUL; opa = rf_r[R_K1]; opb = p00_r; end
      6'd24: begin op = OP_MUL; opa = rf_r[R_K1]; opb = p01_r; end
      6'd25: begin op = OP_SUB; opa = rf_r[R_PAA]; opb = c0_r; end
      6'd26: begin op = OP_SUB; opa = rf_r[R_PAB]; opb = c1_r; end
      6'd27: begin op = OP_SUB; opa = rf_r[R_PBA]; opb = c2_r; end
      6'd28: begin op = OP_SUB; opa = rf_r[R_PBB]; opb = c3_r; end
      default: ;
    endcase
  end

  kabf_alu #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(issue), .op(op), .a(opa), .b(opb),
    .done(alu_done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r[R_ANG]  <= '0;
      rf_r[R_BIAS] <= '0;
      rf_r[R_PAA]  <= '0;
      rf_r[R_PAB]  <= '0;
      rf_r[R_PBA]  <= '0;
      rf_r[R_PBB]  <= '0;
    end else if (load) begin
      rf_r[R_MEAS] <= satw(64'(meas));
      rf_r[R_RATE] <= satw(64'(rate));
      rf_r[R_DT]   <= satw(64'(dt));
      rf_r[R_QA]   <= satw(64'(qa));
      rf_r[R_QB]   <= satw(64'(qb));
      rf_r[R_RM]   <= satw(64'(rm));
    end else if (alu_done) begin
      case (step)
        6'd21: c0_r <= res;
        6'd22: c1_r <= res;
        6'd23: c2_r <= res;
        6'd24: c3_r <= res;
        6'd25: rf_r[R_PAA] <= res;
        6'd26: rf_r[R_PAB] <= res;
        6'd27: rf_r[R_PBA] <= res;
        6'd28: rf_r[R_PBB] <= res;
        default: rf_r[dst] <= res;
      endcase
      if (step == 6'd20) begin
        p00_r <= rf_r[R_PAA];
        p01_r <= rf_r[R_PAB];
      end
    end
  end

  assign angle = EST_W'(rf_r[R_ANG]);

`ifndef SYNTH
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !alu_done) else $error("load while busy");
  a_unused_srcs: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (sa <= 4'd15 && sb <= 4'd15)) else $error("bad source");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |=> !alu_done) else $error("done not a pulse");
`endif
endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import kabf_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [MEAS_W-1:0] measured_angle;
    logic signed [RATE_W-1:0] gyro_rate;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  kabf_in_if  vin ();
  kabf_out_if vout ();

  kalman_angle_bias_filter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (vin.sink),
    .out_ch      (vout.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter shadow: configuration and state
  longint unsigned sh_angle_noise, sh_bias_noise, sh_measure_noise, sh_time_step;
  longint kf_angle, kf_bias, kf_paa, kf_pab, kf_pba, kf_pbb;

  sample_t sample_q[$];
  longint  angle_expect_q[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      cfg_busy = 1'b0;

  function automatic longint sat_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint signed_fin(bit neg, longint unsigned m);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub + 64'd32768) >> 16;
    return signed_fin((a < 0) != (b < 0), p);
  endfunction

  function automatic longint div_q(longint n, longint d);
    longint unsigned un, ud, q, r;
    if (n == 0) return 0;
    if (d == 0) return n < 0 ? QMIN : QMAX;
    un = (n < 0 ? -n : n) << 16;
    ud = d < 0 ? -d : d;
    q = un / ud;
    r = un % ud;
    if (r * 2 >= ud) q++;
    return signed_fin((n < 0) != (d < 0), q);
  endfunction

  function automatic longint filter_step(sample_t s);
    longint dt, t, sv, k0, k1, y, p00, p01;
    dt = longint'(sh_time_step);
    kf_angle = sat_q(kf_angle + mul_q(dt, sat_q(longint'(s.gyro_rate) - kf_bias)));
    t = sat_q(sat_q(sat_q(mul_q(dt, kf_pbb) - kf_pab) - kf_pba) + longint'(sh_angle_noise));
    kf_paa = sat_q(kf_paa + mul_q(dt, t));
    t = mul_q(dt, kf_pbb);
    kf_pab = sat_q(kf_pab - t);
    kf_pba = sat_q(kf_pba - t);
    kf_pbb = sat_q(kf_pbb + mul_q(longint'(sh_bias_noise), dt));
    sv = sat_q(kf_paa + longint'(sh_measure_noise));
    k0 = div_q(kf_paa, sv);
    k1 = div_q(kf_pba, sv);
    y = sat_q(longint'(s.measured_angle) - kf_angle);
    kf_angle = sat_q(kf_angle + mul_q(k0, y));
    kf_bias = sat_q(kf_bias + mul_q(k1, y));
    p00 = kf_paa;
    p01 = kf_pab;
    kf_paa = sat_q(kf_paa - mul_q(k0, p00));
    kf_pab = sat_q(kf_pab - mul_q(k0, p01));
    kf_pba = sat_q(kf_pba - mul_q(k1, p00));
    kf_pbb = sat_q(kf_pbb - mul_q(k1, p01));
    return kf_angle;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    vin.valid = 1'b0;
    vin.measured_angle = '0;
    vin.gyro_rate = '0;
  end

  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      vin.valid <= 1'b0;
    end else begin
      if (vin.valid && vin.ready)
        angle_expect_q.push_back(filter_step({vin.measured_angle, vin.gyro_rate}));
      if (!vin.valid || vin.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          vin.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s = sample_q.pop_front();
          vin.valid <= 1'b1;
          vin.measured_angle <= s.measured_angle;
          vin.gyro_rate <= s.gyro_rate;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left--;
          end
        end else begin
          vin.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode drawn at random from four modes
  int stall_mode = 0;
  int stall_phase = 0;
  initial vout.ready = 1'b0;
  always @(posedge clk) begin
    stall_phase++;
    if (stall_phase % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: vout.ready <= 1'b1;
      1: vout.ready <= $urandom_range(0, 1);
      2: vout.ready <= (stall_phase % 97) > 60;
      default: vout.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor and watchdog
  always @(posedge clk) begin
    longint got;
    if (rst_n && vout.valid && vout.ready) begin
      got = longint'(vout.estimated_angle);
      if (angle_expect_q.size() == 0) begin
        report_mismatch("unexpected estimated_angle", got, 0);
      end else if (got != angle_expect_q[0]) begin
        report_mismatch("estimated_angle", got, angle_expect_q.pop_front());
      end else begin
        void'(angle_expect_q.pop_front());
      end
    end
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready) || cfg_busy || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
  end

  task automatic cfg_write(logic [CFG_AW-1:0] addr, longint unsigned value);
    cfg_busy = 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      ADDR_ANGLE_NOISE:   sh_angle_noise = value & 64'h1FFFF;
      ADDR_BIAS_NOISE:    sh_bias_noise = value & 64'h1FFFF;
      ADDR_MEASURE_NOISE: sh_measure_noise = value & 64'hFFFFF;
      ADDR_TIME_STEP:     sh_time_step = value & 64'h1FFFF;
      default: ;
    endcase
    cfg_busy = 1'b0;
  endtask

  task automatic set_filter(longint unsigned qa, longint unsigned qb,
                            longint unsigned rm, longint unsigned dt);
    cfg_write(ADDR_ANGLE_NOISE, qa);
    cfg_write(ADDR_BIAS_NOISE, qb);
    cfg_write(ADDR_MEASURE_NOISE, rm);
    cfg_write(ADDR_TIME_STEP, dt);
  endtask

  add_sample_dummy_guard: assert final (1);

  task automatic add_sample(longint m, longint r);
    sample_t s;
    s.measured_angle = m[MEAS_W-1:0];
    s.gyro_rate = r[RATE_W-1:0];
    sample_q.push_back(s);
  endtask

  // checked between edges so the driver's updates have settled
  task automatic drain;
    do @(negedge clk);
    while (sample_q.size() != 0 || vin.valid || angle_expect_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // mostly a slowly drifting angle that follows a random rate, some wild samples
  task automatic random_samples(int n);
    longint m, r;
    m = $signed($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        m = $signed($urandom) >>> 7;
        r = $signed($urandom) >>> 4;
      end else begin
        r = $signed($urandom_range(0, 4000000)) - 2000000;
        m = m + (r >>> 7) + ($signed($urandom_range(0, 20000)) - 10000);
        if (m > 11796480 || m < -11796480) m = 0;
      end
      add_sample(m, r);
    end
  endtask

  longint unsigned min_meas = 1;
  initial begin
    sh_angle_noise = RST_ANGLE_NOISE;
    sh_bias_noise = RST_BIAS_NOISE;
    sh_measure_noise = RST_MEASURE_NOISE;
    sh_time_step = RST_TIME_STEP;
    kf_angle = 0; kf_bias = 0;
    kf_paa = 0; kf_pab = 0; kf_pba = 0; kf_pbb = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset, extremes of the inputs
    add_sample(0, 0);
    add_sample(16777215, 134217727);
    add_sample(-16777216, -134217728);
    add_sample(11796480, 131072000);
    add_sample(-11796480, -131072000);
    add_sample(65536, -65536);
    drain();

    // zero time step and zero noise: prediction leaves angle and covariance unchanged
    set_filter(0, 0, 0, 0);
    add_sample(1000, 2000);
    add_sample(-16777216, 134217727);
    drain();

    // largest settings, saturating arithmetic
    set_filter(64'h1FFFF, 64'h1FFFF, 64'hFFFFF, 64'h1FFFF);
    add_sample(16777215, 134217727);
    add_sample(16777215, 134217727);
    add_sample(-16777216, -134217728);
    add_sample(-16777216, -134217728);
    add_sample(0, 0);
    drain();

    set_filter(65536, 65536, 655360, 65536);
    add_sample(11796480, -131072000);
    add_sample(-11796480, 131072000);
    add_sample(0, 0);
    drain();

    set_filter(66, 197, 1966, 655);
    random_samples(450);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_filter($urandom_range(0, 131071) >> $urandom_range(0, 16),
                 $urandom_range(0, 131071) >> $urandom_range(0, 16),
                 $urandom_range(min_meas, 1048575) >> $urandom_range(0, 18),
                 $urandom_range(0, 131071) >> $urandom_range(0, 16));
      random_samples(220);
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/kabf_pkg.sv
rtl/core/kabf_if.sv
rtl/core/kabf_ctrl.sv
rtl/core/kabf_alu.sv
rtl/core/kabf_dp.sv
rtl/core/kalman_angle_bias_filter.sv
test/testbench.sv
